// ===== rtl/core/ihte_pkg.sv =====
// Package for the identity hash table engine: sizes, codes and the key mix.
// No dependencies; every core module imports it.
package ihte_pkg;

  localparam int unsigned TableSize = 128;
  localparam int unsigned IdxW      = $clog2(TableSize);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned Capacity  = (2 * TableSize + 1) / 3;
  localparam int unsigned ProbeShift = 5;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_STORE  = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_SPARE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2,
    MARK_RSVD  = 2'd3
  } mark_e;

  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_MISS       = 3'd1,
    ST_INSERTED   = 3'd2,
    ST_UPDATED    = 3'd3,
    ST_REMOVED    = 3'd4,
    ST_REMOVE_MISSING = 3'd5,
    ST_FULL       = 3'd6,
    ST_RSVD       = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CHECK,
    BK_DONE
  } back_state_e;

  // Queue entry handed from front to back.
  typedef struct packed {
    action_e     action;
    logic [63:0] key;
    logic [63:0] value;
    logic [63:0] hash;
  } job_t;

  function automatic logic [63:0] sar64(logic [63:0] a, int unsigned n);
    return $signed(a) >>> n;
  endfunction

  // First half of the mix: steps one to three.
  function automatic logic [63:0] mix_lo(logic [63:0] key);
    logic [63:0] a;
    a = (key + 64'h7ed55d16) + (key << 12);
    a = (a ^ 64'hc761c23c) ^ sar64(a, 19);
    a = (a + 64'h165667b1) + (a << 5);
    return a;
  endfunction

  // Second half of the mix: steps four to six.
  function automatic logic [63:0] mix_hi(logic [63:0] key);
    logic [63:0] a;
    a = (key + 64'hd3a2646c) ^ (key << 9);
    a = (a + 64'hfd7046c5) + (a << 3);
    a = (a ^ 64'hb55a4f09) ^ sar64(a, 16);
    return a;
  endfunction

endpackage

// ===== rtl/core/ihte_front.sv =====
// Front end: accepts requests and computes the key mix over two stages.
// Depends on ihte_pkg.
module ihte_front import ihte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [63:0] lookup_key_i,
  input  logic [63:0] new_value_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output job_t        job_o
);

  logic        s1_valid_q, s1_valid_d;
  job_t        s1_q;
  logic        s2_valid_q, s2_valid_d;
  job_t        s2_q;
  logic        s2_adv, s1_adv;

  assign s2_adv     = !s2_valid_q || job_ready_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_ready_o = s1_adv;

  assign s1_valid_d = s1_adv ? in_valid_i : s1_valid_q;
  assign s2_valid_d = s2_adv ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_q.action <= action_e'(action_i);
      s1_q.key    <= lookup_key_i;
      s1_q.value  <= new_value_i;
      s1_q.hash   <= mix_lo(lookup_key_i);
    end
    if (s2_adv && s1_valid_q) begin
      s2_q.action <= s1_q.action;
      s2_q.key    <= s1_q.key;
      s2_q.value  <= s1_q.value;
      s2_q.hash   <= mix_hi(s1_q.hash);
    end
  end

  assign job_valid_o = s2_valid_q;
  assign job_o       = s2_q;

endmodule

// ===== rtl/core/ihte_queue.sv =====
// Two-entry queue between the front end and the probe engine.
// Depends on ihte_pkg.
module ihte_queue import ihte_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_data_o
);

  job_t       mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rptr_q];

  assign wptr_d = wr_en ? !wptr_q : wptr_q;
  assign rptr_d = rd_en ? !rptr_q : rptr_q;
  assign cnt_d  = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wptr_q] <= wr_data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !rd_en) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count missed a write");

endmodule

// ===== rtl/core/ihte_back.sv =====
// Probe engine: walks the slot memories, applies the action, holds the result.
// Depends on ihte_pkg.
module ihte_back import ihte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] found_value_o,
  output logic [6:0]  live_entries_o
);

  back_state_e state_q, state_d;

  logic [63:0] key_mem_q [TableSize];
  logic [63:0] val_mem_q [TableSize];
  logic [TableSize-1:0] live_q, tomb_q;

  job_t          job_q;
  logic [63:0]   idx_q, idx_d, pert_q, pert_d;
  logic [CntW-1:0] steps_q, steps_d;
  logic          has_free_q, has_free_d;
  logic [IdxW-1:0] free_q, free_d;
  logic [IdxW-1:0] slot;
  logic [63:0]   rd_key_q, rd_val_q;
  logic          rd_live_q, rd_tomb_q;
  logic [IdxW-1:0] rd_slot_q;
  logic [6:0]    live_cnt_q, live_cnt_d;

  logic          res_valid_q;
  status_e       res_status_q, res_status_d;
  logic [63:0]   res_value_q, res_value_d;

  logic          hit, empty, walk_end, finish;
  logic          wr_key, wr_val, set_live, set_tomb;
  logic [IdxW-1:0] wr_slot;

  assign slot        = idx_q[IdxW-1:0];
  assign job_ready_o = (state_q == BK_IDLE);
  assign hit         = rd_live_q && (rd_key_q == job_q.key);
  assign empty       = !rd_live_q && !rd_tomb_q;
  assign walk_end    = (steps_q == CntW'(TableSize - 1));
  assign finish      = hit || empty || walk_end;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (job_valid_i) state_d = BK_READ;
      BK_READ:  state_d = BK_CHECK;
      BK_CHECK: state_d = finish ? BK_DONE : BK_READ;
      BK_DONE:  if (!res_valid_q || out_ready_i) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // Walk bookkeeping and the decision at the end of the walk.
  always_comb begin
    idx_d      = idx_q;
    pert_d     = pert_q;
    steps_d    = steps_q;
    has_free_d = has_free_q;
    free_d     = free_q;
    live_cnt_d = live_cnt_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    wr_key = 1'b0; wr_val = 1'b0; set_live = 1'b0; set_tomb = 1'b0;
    wr_slot = rd_slot_q;
    unique case (state_q)
      BK_IDLE: begin
        idx_d      = job_i.hash & 64'(TableSize - 1);
        pert_d     = job_i.hash;
        steps_d    = '0;
        has_free_d = 1'b0;
        free_d     = '0;
      end
      BK_CHECK: begin
        if (!hit && !has_free_q && (empty || rd_tomb_q)) begin
          has_free_d = 1'b1;
          free_d     = rd_slot_q;
        end
        idx_d   = (idx_q << 2) + idx_q + pert_q + 64'd1;
        pert_d  = pert_q >> ProbeShift;
        steps_d = steps_q + 1'b1;
      end
      default: ;
    endcase
    res_value_d = '0;
    if (state_q == BK_CHECK && finish) begin
      case (job_q.action)
        ACT_STORE: begin
          if (hit) begin
            wr_val = 1'b1;
            res_status_d = ST_UPDATED;
          end else if (live_cnt_q >= 7'(Capacity) || !has_free_d) begin
            res_status_d = ST_FULL;
          end else begin
            wr_slot  = free_d;
            wr_key   = 1'b1;
            wr_val   = 1'b1;
            set_live = 1'b1;
            live_cnt_d = live_cnt_q + 7'd1;
            res_status_d = ST_INSERTED;
          end
        end
        ACT_REMOVE: begin
          if (hit) begin
            set_tomb = 1'b1;
            if (live_cnt_q != 7'd0) live_cnt_d = live_cnt_q - 7'd1;
            res_status_d = ST_REMOVED;
          end else begin
            res_status_d = ST_REMOVE_MISSING;
          end
        end
        default: begin
          res_status_d = hit ? ST_HIT : ST_MISS;
          res_value_d  = hit ? rd_val_q : 64'd0;
        end
      endcase
    end else begin
      res_value_d = res_value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      live_q      <= '0;
      tomb_q      <= '0;
      live_cnt_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      live_cnt_q <= live_cnt_d;
      if (set_live) begin
        live_q[wr_slot] <= 1'b1;
        tomb_q[wr_slot] <= 1'b0;
      end
      if (set_tomb) begin
        live_q[wr_slot] <= 1'b0;
        tomb_q[wr_slot] <= 1'b1;
      end
      if (state_q == BK_DONE && state_d == BK_IDLE) res_valid_q <= 1'b1;
      else if (out_ready_i) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE && job_valid_i) job_q <= job_i;
    idx_q      <= idx_d;
    pert_q     <= pert_d;
    steps_q    <= steps_d;
    has_free_q <= has_free_d;
    free_q     <= free_d;
    if (state_q == BK_READ) begin
      rd_key_q  <= key_mem_q[slot];
      rd_val_q  <= val_mem_q[slot];
      rd_live_q <= live_q[slot];
      rd_tomb_q <= tomb_q[slot];
      rd_slot_q <= slot;
    end
    if (state_q == BK_CHECK && finish) begin
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
    end
    if (state_q == BK_DONE && state_d == BK_IDLE) begin
      status_o       <= res_status_q;
      found_value_o  <= res_value_q;
      live_entries_o <= live_cnt_q;
    end
  end

  // Key and value memories, one write port each.
  always_ff @(posedge clk_i) begin
    if (wr_key) key_mem_q[wr_slot] <= job_q.key;
    if (wr_val) val_mem_q[wr_slot] <= job_q.value;
  end

  assign out_valid_o = res_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) (live_q & tomb_q) == '0)
    else $error("slot both live and tombstone");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_cnt_q <= 7'(Capacity))
    else $error("live count above capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_CHECK && finish && job_q.action == ACT_STORE && !hit &&
     res_status_d == ST_INSERTED) |=> live_cnt_q == $past(live_cnt_q) + 7'd1)
    else $error("insert did not count");

endmodule

// ===== rtl/core/identity_hash_table_engine.sv =====
// Identity hash table engine: 128-slot open-addressing map, 64-bit keys/values.
// Path: the key mix is registered over two front-end stages, the job waits in the
// two-entry queue, then the probe engine reads and checks each probed slot in turn
// and finishes; it takes a new operation only once the last one has left BK_DONE.
// Reset: asynchronous, clears slot marks, live count and all handshake state.
// Depends on ihte_pkg, ihte_front, ihte_queue, ihte_back.
module identity_hash_table_engine import ihte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [63:0] lookup_key_i,
  input  logic [63:0] new_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] found_value_o,
  output logic [6:0]  live_entries_o
);

  logic f_valid, f_ready, q_valid, q_ready;
  job_t f_job, q_job;

  ihte_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .lookup_key_i,
    .new_value_i, .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  ihte_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_job),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_job)
  );

  ihte_back u_back (
    .clk_i, .rst_ni, .job_valid_i(q_valid), .job_ready_o(q_ready), .job_i(q_job),
    .out_valid_o, .out_ready_i, .status_o, .found_value_o, .live_entries_o
  );

endmodule

// ===== sim/tb_top.sv =====
// Testbench for identity_hash_table_engine: drives lookup/store/remove/spare transfers
// and checks every result against an in-bench model of the probed map.
// Depends on ihte_pkg and the engine RTL.
module tb_top;
  import ihte_pkg::*;

  localparam int unsigned NSlots = 128;
  localparam int unsigned MaxLive = (2 * NSlots + 1) / 3;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] value;
    logic [6:0]  live;
  } answer_t;

  class map_scoreboard;
    logic [63:0] keys [NSlots];
    logic [63:0] vals [NSlots];
    mark_e       marks [NSlots];
    int unsigned live_cnt;
    answer_t     pending [$];
    int unsigned mismatches;

    function void clear();
      foreach (marks[s]) begin
        marks[s] = MARK_EMPTY;
        keys[s] = '0;
        vals[s] = '0;
      end
      live_cnt = 0;
    endfunction

    function logic [63:0] mix(logic [63:0] a);
      a = (a + 64'h7ed55d16) + (a << 12);
      a = (a ^ 64'hc761c23c) ^ 64'($signed(a) >>> 19);
      a = (a + 64'h165667b1) + (a << 5);
      a = (a + 64'hd3a2646c) ^ (a << 9);
      a = (a + 64'hfd7046c5) + (a << 3);
      a = (a ^ 64'hb55a4f09) ^ 64'($signed(a) >>> 16);
      return a;
    endfunction

    function void note_transfer(logic [1:0] act, logic [63:0] key, logic [63:0] val);
      logic [63:0] h, idx, pert;
      int unsigned slot, hit_slot, free_slot;
      bit found, has_free;
      answer_t ans;
      h = mix(key);
      idx = h & 64'(NSlots - 1);
      pert = h;
      found = 0;
      has_free = 0;
      hit_slot = 0;
      free_slot = 0;
      for (int n = 0; n < NSlots; n++) begin
        slot = 32'(idx & 64'(NSlots - 1));
        if (marks[slot] == MARK_LIVE && keys[slot] == key) begin
          found = 1;
          hit_slot = slot;
          break;
        end
        if (marks[slot] == MARK_EMPTY) begin
          if (!has_free) begin
            free_slot = slot;
            has_free = 1;
          end
          break;
        end
        if (marks[slot] == MARK_TOMB && !has_free) begin
          free_slot = slot;
          has_free = 1;
        end
        idx = (idx << 2) + idx + pert + 64'd1;
        pert = pert >> ProbeShift;
      end
      ans.value = '0;
      if (act == ACT_STORE) begin
        if (found) begin
          vals[hit_slot] = val;
          ans.status = ST_UPDATED;
        end else if (live_cnt >= MaxLive || !has_free) begin
          ans.status = ST_FULL;
        end else begin
          keys[free_slot] = key;
          vals[free_slot] = val;
          marks[free_slot] = MARK_LIVE;
          live_cnt++;
          ans.status = ST_INSERTED;
        end
      end else if (act == ACT_REMOVE) begin
        if (found) begin
          marks[hit_slot] = MARK_TOMB;
          if (live_cnt > 0) live_cnt--;
          ans.status = ST_REMOVED;
        end else begin
          ans.status = ST_REMOVE_MISSING;
        end
      end else if (found) begin
        ans.value = vals[hit_slot];
        ans.status = ST_HIT;
      end else begin
        ans.status = ST_MISS;
      end
      ans.live = live_cnt[6:0];
      pending.push_back(ans);
    endfunction

    function void check_result(logic [2:0] st, logic [63:0] fv, logic [6:0] le);
      answer_t exp_ans;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", st);
        return;
      end
      exp_ans = pending.pop_front();
      if (st !== exp_ans.status || fv !== exp_ans.value || le !== exp_ans.live) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d val=%h live=%0d, got st=%0d val=%h live=%0d",
                   exp_ans.status, exp_ans.value, exp_ans.live, st, fv, le);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [1:0]  action_i = '0;
  logic [63:0] lookup_key_i = '0;
  logic [63:0] new_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [2:0]  status_o;
  logic [63:0] found_value_o;
  logic [6:0]  live_entries_o;

  identity_hash_table_engine dut (.*);

  map_scoreboard board = new();
  logic [63:0] key_pool [48];
  bit sending_done = 0;
  bit hold_receiver = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Hold valid low for the gap, then present one item and hold it until its transfer.
  // Valid stays high after the transfer so back-to-back items need no gap.
  task automatic send_op(logic [1:0] act, logic [63:0] key, logic [63:0] val, int gap);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1;
    action_i <= act;
    lookup_key_i <= key;
    new_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_transfer(act, key, val);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected result has come.
  task automatic drain();
    in_valid_i <= 0;
    do @(negedge clk_i); while (board.pending.size() != 0);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 47)];
    return rand64();
  endfunction

  // Receiver: random ready stalls, long hold-offs when requested.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_receiver) begin
        out_ready_i <= 0;
        repeat (300) @(negedge clk_i);
        hold_receiver = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_ready_i <= 0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!out_valid_o);
      board.check_result(status_o, found_value_o, live_entries_o);
    end
  end

  initial begin
    int gap;
    board.clear();
    foreach (key_pool[k]) key_pool[k] = rand64();
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    // Directed: extremes, every action, spare action, update, remove, miss.
    send_op(ACT_LOOKUP, '0, '0, 0);
    send_op(ACT_REMOVE, '0, '0, 0);
    send_op(ACT_STORE, '0, '1, 1);
    send_op(ACT_STORE, '1, '0, 0);
    send_op(ACT_LOOKUP, '0, '0, 0);
    send_op(ACT_SPARE, '1, '1, 2);
    send_op(ACT_STORE, '0, 64'h5555_aaaa_5555_aaaa, 0);
    send_op(ACT_LOOKUP, '0, '0, 0);
    send_op(ACT_REMOVE, '0, '0, 0);
    send_op(ACT_LOOKUP, '0, '0, 0);
    send_op(ACT_REMOVE, '0, '0, 0);
    send_op(ACT_STORE, 64'h8000_0000_0000_0000, 64'haaaa_5555_aaaa_5555, 0);
    send_op(ACT_SPARE, 64'h8000_0000_0000_0000, '0, 0);
    drain();
    // Fill to capacity so stores get refused, then empty it again.
    for (int n = 0; n < MaxLive + 4; n++)
      send_op(ACT_STORE, rand64(), rand64(), 0);
    send_op(ACT_STORE, '1, '0, 0);
    for (int s = 0; s < NSlots; s++)
      if (board.marks[s] == MARK_LIVE) send_op(ACT_REMOVE, board.keys[s], '0, 0);
    drain();
    // Random traffic over a small key pool so hits, updates and tombstones recur.
    for (int n = 0; n < 1300; n++) begin
      if (n == 200) hold_receiver = 1;
      if (n == 600) drain();
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (n < 400 && n >= 200) gap = 0;
      send_op(2'($urandom_range(0, 3)), pick_key(), rand64(), gap);
    end
    drain();
    repeat (200) @(negedge clk_i);
    if (board.mismatches == 0 && board.pending.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_top failed");
    $finish;
  end
endmodule
